@@ src/assert_macros.svh @@
// Assertion helpers shared by the screen's modules.
// Both forms sample on clk and are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SPT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spt: check failed");
`define SPT_ASSERT_IMP(label, ante, cons) \
  `SPT_ASSERT(label, (ante) |-> (cons))
`else
`define SPT_ASSERT(label, prop)
`define SPT_ASSERT_IMP(label, ante, cons)
`endif

`endif

@@ src/spt_pkg.sv @@
package spt_pkg;

  localparam int CAND_W      = 32;
  localparam int DIV_BITS    = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_BITS);
  localparam int FIRST_PRIME = 2;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic clr_write;    // set the mark at the sweep address, advance the sweep
    logic n_init;       // start the sieve at the first prime
    logic mark_read;    // read the mark of n
    logic keep;         // record n in the prime table
    logic strike_init;  // first multiple to strike is 2n
    logic strike;       // clear the mark of the current multiple, step by n
    logic n_adv;        // next sieve number
    logic cand_load;    // latch the magnitude of a request, restart the table walk
    logic tbl_read;     // read the table prime at the walk index
    logic div_start;    // divide the magnitude by the table prime just read
    logic k_adv;        // next table entry
  } spt_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic clr_last;
    logic n_last;
    logic mark;
    logic m_in_range;
    logic count_zero;
    logic k_last;
    logic div_done;
    logic div_zero;
  } spt_sts_t;

endpackage

@@ src/spt_div.sv @@
`include "assert_macros.svh"

module spt_div import spt_pkg::*; #(
  parameter int DVW = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CAND_W-1:0] dividend,
  input  logic [DVW-1:0]    divisor,
  output logic              done,
  output logic              rem_zero
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CAND_W-1:0]    sh;
  logic [DVW-1:0]       dvs;
  logic [DVW-1:0]       rem;
  logic [DVW:0]         trial;
  logic                 ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem, sh[CAND_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        sh   <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? DVW'(trial - {1'b0, dvs}) : trial[DVW-1:0];
        sh  <= {sh[CAND_W-2:0], 1'b0};
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem_zero = rem == '0;

  `SPT_ASSERT_IMP(a_div_no_restart, start, !busy)
  `SPT_ASSERT_IMP(a_div_done_after_busy, done, $past(busy))

endmodule

@@ src/spt_dpath.sv @@
`include "assert_macros.svh"

module spt_dpath import spt_pkg::*; #(
  parameter int SIEVE_LIMIT = 1000,
  parameter int TABLE_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [CAND_W-1:0] candidate,
  input  spt_cmd_t                 cmd,
  output spt_sts_t                 sts
);

  localparam int AW  = $clog2(SIEVE_LIMIT);
  localparam int MW  = AW + 1;
  localparam int TIW = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);

  logic              marks [SIEVE_LIMIT];
  logic [AW-1:0]     primes [TABLE_DEPTH];

  logic [AW-1:0]     clr;
  logic [AW-1:0]     n;
  logic [MW-1:0]     m;
  logic              mark_q;
  logic [CW-1:0]     count;
  logic              count_full;
  logic [TIW-1:0]    k;
  logic [AW-1:0]     tbl_q;
  logic [CAND_W-1:0] mag;
  logic [CAND_W-1:0] cand_u;
  logic              div_done;
  logic              div_zero;

  assign cand_u     = candidate;
  assign count_full = count == CW'(TABLE_DEPTH);

  // Sieve bitmap: set by the sweep, struck by the sieve, read one number at a time.
  always_ff @(posedge clk) begin
    if (cmd.clr_write) begin
      marks[clr] <= 1'b1;
    end else if (cmd.strike) begin
      marks[m[AW-1:0]] <= 1'b0;
    end
    if (cmd.mark_read) begin
      mark_q <= marks[n];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.keep && !count_full) begin
      primes[count[TIW-1:0]] <= n;
    end
    if (cmd.tbl_read) begin
      tbl_q <= primes[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr   <= '0;
      count <= '0;
    end else begin
      if (cmd.clr_write) begin
        clr <= clr + AW'(1);
      end
      if (cmd.keep && !count_full) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.n_init) begin
      n <= AW'(FIRST_PRIME);
    end else if (cmd.n_adv) begin
      n <= n + AW'(1);
    end
    if (cmd.strike_init) begin
      m <= {n, 1'b0};
    end else if (cmd.strike) begin
      m <= m + MW'(n);
    end
    if (cmd.cand_load) begin
      mag <= cand_u[CAND_W-1] ? (~cand_u + CAND_W'(1)) : cand_u;
      k   <= '0;
    end else if (cmd.k_adv) begin
      k <= k + TIW'(1);
    end
  end

  spt_div #(
    .DVW (AW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (tbl_q),
    .done     (div_done),
    .rem_zero (div_zero)
  );

  always_comb begin
    sts.clr_last   = clr == AW'(SIEVE_LIMIT - 1);
    sts.n_last     = n == AW'(SIEVE_LIMIT - 1);
    sts.mark       = mark_q;
    sts.m_in_range = m < MW'(SIEVE_LIMIT);
    sts.count_zero = count == '0;
    sts.k_last     = (CW'(k) + CW'(1)) == count;
    sts.div_done   = div_done;
    sts.div_zero   = div_zero;
  end

  `SPT_ASSERT(a_count_bounded, count <= CW'(TABLE_DEPTH))
  `SPT_ASSERT_IMP(a_walk_in_table, cmd.tbl_read, CW'(k) < count)

endmodule

@@ src/spt_ctrl.sv @@
`include "assert_macros.svh"

module spt_ctrl import spt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     candidate_valid,
  output logic     candidate_stall,
  output logic     passes_valid,
  output logic     passes,
  input  logic     passes_stall,
  output spt_cmd_t cmd,
  input  spt_sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_SV_RD,
    S_SV_CHK,
    S_STRIKE,
    S_IDLE,
    S_TB_RD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  state_t state;
  logic   verdict;
  logic   take;
  logic   out_load;

  assign candidate_stall = state != S_IDLE;
  assign take            = candidate_valid && !candidate_stall;
  assign out_load        = (state == S_FINISH) && (!passes_valid || !passes_stall);

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        cmd.n_init    = sts.clr_last;
      end
      S_SV_RD: begin
        cmd.mark_read = 1'b1;
      end
      S_SV_CHK: begin
        cmd.keep        = sts.mark;
        cmd.strike_init = sts.mark;
        cmd.n_adv       = !sts.mark && !sts.n_last;
      end
      S_STRIKE: begin
        cmd.strike = sts.m_in_range;
        cmd.n_adv  = !sts.m_in_range && !sts.n_last;
      end
      S_IDLE: begin
        cmd.cand_load = take;
      end
      S_TB_RD: begin
        cmd.tbl_read = 1'b1;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
      end
      S_DIV_WAIT: begin
        cmd.k_adv = sts.div_done && !sts.div_zero && !sts.k_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      passes_valid <= 1'b0;
    end else begin
      if (out_load) begin
        passes_valid <= 1'b1;
        passes       <= verdict;
      end else if (passes_valid && !passes_stall) begin
        passes_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (sts.clr_last) state <= S_SV_RD;
        end
        S_SV_RD: begin
          state <= S_SV_CHK;
        end
        S_SV_CHK: begin
          if (sts.mark) begin
            state <= S_STRIKE;
          end else if (sts.n_last) begin
            state <= S_IDLE;
          end else begin
            state <= S_SV_RD;
          end
        end
        S_STRIKE: begin
          if (!sts.m_in_range) state <= sts.n_last ? S_IDLE : S_SV_RD;
        end
        S_IDLE: begin
          if (take) begin
            // an empty table lets everything through
            if (sts.count_zero) begin
              verdict <= 1'b1;
              state   <= S_FINISH;
            end else begin
              state <= S_TB_RD;
            end
          end
        end
        S_TB_RD: begin
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            if (sts.div_zero) begin
              verdict <= 1'b0;
              state   <= S_FINISH;
            end else if (sts.k_last) begin
              verdict <= 1'b1;
              state   <= S_FINISH;
            end else begin
              state <= S_TB_RD;
            end
          end
        end
        S_FINISH: begin
          // hold the verdict until the output register is free
          if (out_load) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SPT_ASSERT_IMP(a_result_from_finish, $rose(passes_valid), $past(state == S_FINISH))
  `SPT_ASSERT_IMP(a_accept_leaves_idle, take, ##1 (state != S_IDLE))

endmodule

@@ src/small_prime_trial_division.sv @@
// Small-prime trial-division screen.
// Request channel: candidate (signed 32 bits) with candidate_valid and
// candidate_stall; a request is taken at a clock edge with valid high and
// stall low. Result channel: passes with passes_valid and passes_stall;
// passes is 1 when no prime below SIEVE_LIMIT divides |candidate|, so zero
// and the small primes themselves come back 0.
// After rst the block sweeps the mark bitmap to all set, then runs the sieve,
// recording each surviving number in the prime table. candidate_stall stays
// high through both passes.
// One request at a time: per table prime, S_TB_RD reads the table, S_DIV_GO
// starts the divider, and S_DIV_WAIT waits while the single bit-serial
// remainder unit runs its 32 shift-subtract steps to done. A candidate that
// no prime divides walks the whole table (168 primes by default); a
// divisible one stops at the first hit.
// The result sits in an output register; while passes_stall is high it
// holds, and the next request is accepted but its verdict waits in S_FINISH.
module small_prime_trial_division import spt_pkg::*; #(
  parameter int SIEVE_LIMIT = 1000,
  parameter int TABLE_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [CAND_W-1:0] candidate,
  input  logic                     candidate_valid,
  output logic                     candidate_stall,
  output logic                     passes,
  output logic                     passes_valid,
  input  logic                     passes_stall
);

  spt_cmd_t cmd;
  spt_sts_t sts;

  spt_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .candidate_valid (candidate_valid),
    .candidate_stall (candidate_stall),
    .passes_valid    (passes_valid),
    .passes          (passes),
    .passes_stall    (passes_stall),
    .cmd             (cmd),
    .sts             (sts)
  );

  spt_dpath #(
    .SIEVE_LIMIT (SIEVE_LIMIT),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .candidate (candidate),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
